### design/pidz_pkg.sv
package pidz_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int QUEUE_DEPTH   = 2;
  localparam int CFG_IDX_W     = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET        = 3'd0,
    REG_PROP_GAIN     = 3'd1,
    REG_INTEG_GAIN    = 3'd2,
    REG_DERIV_GAIN    = 3'd3,
    REG_MAX_INTEGRAL  = 3'd4,
    REG_INTEGRAL_ZONE = 3'd5,
    REG_OUTPUT_LIMIT  = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0] target;
    logic [31:0] prop_gain;
    logic [31:0] integ_gain;
    logic [31:0] deriv_gain;
    logic [30:0] max_integral;
    logic [30:0] integral_zone;
    logic [30:0] output_limit;
  } cfg_t;

  // One classified sample as it waits between the front and the back.
  typedef struct packed {
    logic [31:0] err;
    logic        in_zone;
  } front_item_t;

  function automatic logic [31:0] sat32(input logic signed [65:0] v);
    logic [31:0] res;
    if (v > 66'sd2147483647) begin
      res = 32'h7fff_ffff;
    end else if (v < -66'sd2147483648) begin
      res = 32'h8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  // Two-bit code for sign(v): zero, positive or negative.
  function automatic logic [1:0] sign_code(input logic [31:0] v);
    logic [1:0] res;
    if (v == '0) begin
      res = 2'b00;
    end else if (v[31]) begin
      res = 2'b11;
    end else begin
      res = 2'b01;
    end
    return res;
  endfunction

endpackage

### design/pid_controller_izone_clamp.sv
// Fixed-point PID controller with integral zone, integral clear on error sign change and
// integral magnitude limit. Each transfer on the in_ channel carries one signed reading
// (FRAC_BITS fraction bits); each transfer on the out_ channel returns the clamped drive and
// the saturated error target - reading, one result per reading, in order. One reading is
// taken per clock for as long as the result side keeps up. The front computes and
// classifies the error into a two-entry queue; the back runs a five-stage pipeline whose
// integral update reads and writes the accumulator within the integral stage, which is what
// holds the rate at one item per cycle while the output is not stalled. Registers are written through
// the cfg_ channel (index 0 target, 1 prop_gain, 2 integ_gain, 3 deriv_gain,
// 4 max_integral, 5 integral_zone, 6 output_limit; index 7 is ignored) and must only be
// written while no reading is in flight. After reset all registers are zero except
// output_limit, which is 1.0.
module pid_controller_izone_clamp
  import pidz_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [31:0]   in_reading,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   out_drive,
  output logic signed [31:0]   out_error_now,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  // All registers clear except output_limit, which resets to 1.0.
  localparam cfg_t CFG_RESET = {32'd0, 32'd0, 32'd0, 32'd0, 31'd0, 31'd0,
                                31'(1) << FRAC_BITS};

  cfg_t        cfg_r, cfg_nxt;
  front_item_t front_item, head_item;
  logic        q_full, q_push, q_pop, q_head_valid;
  logic [31:0] drive_w, error_w;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_TARGET:        cfg_nxt.target        = cfg_data;
        REG_PROP_GAIN:     cfg_nxt.prop_gain     = cfg_data;
        REG_INTEG_GAIN:    cfg_nxt.integ_gain    = cfg_data;
        REG_DERIV_GAIN:    cfg_nxt.deriv_gain    = cfg_data;
        REG_MAX_INTEGRAL:  cfg_nxt.max_integral  = cfg_data[30:0];
        REG_INTEGRAL_ZONE: cfg_nxt.integral_zone = cfg_data[30:0];
        REG_OUTPUT_LIMIT:  cfg_nxt.output_limit  = cfg_data[30:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  pidz_front u_front (
    .target        (cfg_r.target),
    .integral_zone (cfg_r.integral_zone),
    .reading       (in_reading),
    .item          (front_item)
  );

  pidz_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (front_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_item  (head_item)
  );

  pidz_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .head_valid    (q_head_valid),
    .head_item     (head_item),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_drive     (drive_w),
    .out_error_now (error_w)
  );

  assign out_drive     = drive_w;
  assign out_error_now = error_w;

endmodule

### design/pidz_front.sv
module pidz_front
  import pidz_pkg::*;
(
  input  logic [31:0]  target,
  input  logic [30:0]  integral_zone,
  input  logic [31:0]  reading,
  output front_item_t  item
);

  logic signed [32:0] diff;
  logic [31:0]        err;
  logic [31:0]        mag;

  always_comb begin
    diff = $signed({target[31], target}) - $signed({reading[31], reading});
    // The two top bits disagree only when the difference left the 32-bit range.
    if (diff[32] != diff[31]) begin
      err = diff[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      err = diff[31:0];
    end
    mag = err[31] ? (32'd0 - err) : err;
    item.err     = err;
    item.in_zone = (mag < {1'b0, integral_zone});
  end

endmodule

### design/pidz_queue.sv
module pidz_queue
  import pidz_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  front_item_t push_item,
  output logic        full,
  input  logic        pop,
  output logic        head_valid,
  output front_item_t head_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  front_item_t        mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count exceeds depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full && !pop |-> !push)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from empty queue");

endmodule

### design/pidz_back.sv
module pidz_back
  import pidz_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        head_valid,
  input  front_item_t head_item,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_drive,
  output logic [31:0] out_error_now
);

  // Stage valids: 1 error difference, 2 products, 3 scaling, 4 integral, 5 output.
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic v1_nxt, v2_nxt, v3_nxt, v4_nxt, v5_nxt;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic ld1, ld2, ld3, ld4, ld5;

  logic [31:0]        prev_error_r;
  logic [31:0]        integral_acc_r, integral_acc_nxt;

  logic [31:0]        e1_r;
  logic signed [32:0] diff1_r;
  logic               zone1_r, clr1_r;

  logic signed [63:0] prod_p2_r, prod_i2_r;
  logic signed [64:0] prod_d2_r;
  logic [31:0]        e2_r;
  logic               zone2_r, clr2_r;

  logic [31:0]        p3_r, i3_r, d3_r, e3_r;
  logic               zone3_r, clr3_r;

  logic [31:0]        p4_r, d4_r, e4_r;

  logic [31:0]        drive5_r, e5_r;

  logic signed [32:0] acc_sum;
  logic [31:0]        acc_add, acc_sel;
  logic signed [32:0] acc_ext, lim_int;
  logic signed [33:0] drive_sum, lim_out;
  logic [31:0]        drive_nxt;

  assign rdy5 = !v5_r || out_ready;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign pop  = head_valid && rdy1;

  assign ld1 = pop;
  assign ld2 = v1_r && rdy2;
  assign ld3 = v2_r && rdy3;
  assign ld4 = v3_r && rdy4;
  assign ld5 = v4_r && rdy5;

  assign v1_nxt = rdy1 ? head_valid : v1_r;
  assign v2_nxt = rdy2 ? v1_r : v2_r;
  assign v3_nxt = rdy3 ? v2_r : v3_r;
  assign v4_nxt = rdy4 ? v3_r : v4_r;
  assign v5_nxt = rdy5 ? v4_r : v5_r;

  // Integral update: accumulate inside the zone, clear on a sign change, then limit.
  always_comb begin
    acc_sum = $signed({integral_acc_r[31], integral_acc_r}) + $signed({i3_r[31], i3_r});
    acc_add = sat32(66'(acc_sum));
    acc_sel = zone3_r ? acc_add : integral_acc_r;
    if (clr3_r) begin
      acc_sel = '0;
    end
    acc_ext = $signed({acc_sel[31], acc_sel});
    lim_int = $signed({2'b00, cfg.max_integral});
    if (acc_ext > lim_int) begin
      integral_acc_nxt = lim_int[31:0];
    end else if (acc_ext < -lim_int) begin
      integral_acc_nxt = 32'(-lim_int);
    end else begin
      integral_acc_nxt = acc_sel;
    end
  end

  always_comb begin
    drive_sum = 34'($signed(p4_r)) + 34'($signed(d4_r)) + 34'($signed(integral_acc_r));
    lim_out   = $signed({3'b000, cfg.output_limit});
    if (drive_sum > lim_out) begin
      drive_nxt = lim_out[31:0];
    end else if (drive_sum < -lim_out) begin
      drive_nxt = 32'(-lim_out);
    end else begin
      drive_nxt = drive_sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r           <= 1'b0;
      v2_r           <= 1'b0;
      v3_r           <= 1'b0;
      v4_r           <= 1'b0;
      v5_r           <= 1'b0;
      prev_error_r   <= '0;
      integral_acc_r <= '0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
      v5_r <= v5_nxt;
      if (ld1) begin
        prev_error_r <= head_item.err;
      end
      if (ld4) begin
        integral_acc_r <= integral_acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      e1_r    <= head_item.err;
      diff1_r <= $signed({head_item.err[31], head_item.err})
               - $signed({prev_error_r[31], prev_error_r});
      zone1_r <= head_item.in_zone;
      clr1_r  <= (sign_code(head_item.err) != sign_code(prev_error_r));
    end
    if (ld2) begin
      prod_p2_r <= $signed(cfg.prop_gain) * $signed(e1_r);
      prod_i2_r <= $signed(e1_r) * $signed(cfg.integ_gain);
      prod_d2_r <= $signed(cfg.deriv_gain) * diff1_r;
      e2_r      <= e1_r;
      zone2_r   <= zone1_r;
      clr2_r    <= clr1_r;
    end
    if (ld3) begin
      // Arithmetic shift of the exact product rounds toward minus infinity.
      p3_r    <= sat32(66'(prod_p2_r) >>> FRAC_BITS);
      i3_r    <= sat32(66'(prod_i2_r) >>> FRAC_BITS);
      d3_r    <= sat32(66'(prod_d2_r) >>> FRAC_BITS);
      e3_r    <= e2_r;
      zone3_r <= zone2_r;
      clr3_r  <= clr2_r;
    end
    if (ld4) begin
      p4_r <= p3_r;
      d4_r <= d3_r;
      e4_r <= e3_r;
    end
    if (ld5) begin
      drive5_r <= drive_nxt;
      e5_r     <= e4_r;
    end
  end

  assign out_valid     = v5_r;
  assign out_drive     = drive5_r;
  assign out_error_now = e5_r;

  a_integral_limit: assert property (@(posedge clk) disable iff (!rst_n)
    ld4 |=> ($signed({integral_acc_r[31], integral_acc_r})
             <= $signed({2'b00, $past(cfg.max_integral)}))
         && ($signed({integral_acc_r[31], integral_acc_r})
             >= -$signed({2'b00, $past(cfg.max_integral)})))
    else $error("integral outside its magnitude limit");

  a_sign_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ld4 && clr3_r |=> integral_acc_r == '0)
    else $error("integral not cleared on error sign change");

  a_drive_limit: assert property (@(posedge clk) disable iff (!rst_n)
    ld5 |=> ($signed({out_drive[31], out_drive}) <= $signed({2'b00, $past(cfg.output_limit)}))
         && ($signed({out_drive[31], out_drive}) >= -$signed({2'b00, $past(cfg.output_limit)})))
    else $error("drive outside output limit");

  a_prev_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    ld1 |=> prev_error_r == e1_r)
    else $error("previous error not tracking newest sample");

endmodule
